// File: hdl/dvew_pkg.sv
// ----------------------------------------------------------------------------
// dvew_pkg
// Constants and calendar tables for the date check and epoch conversion.
// ----------------------------------------------------------------------------
package dvew_pkg;

    localparam int unsigned DAY_W     = 5;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned DAYS_W    = 16;
    localparam int unsigned SECS_W    = 32;
    localparam int unsigned WDAY_W    = 3;
    localparam int unsigned YOFS_W    = 8;
    localparam int unsigned SUM_W     = 17;
    localparam int unsigned MOD_SHIFT = 19;

    localparam logic [YEAR_W-1:0]  YEAR_MIN      = 12'd1970;
    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 12'd2099;
    localparam logic [YEAR_W-1:0]  YEAR_BASE     = 12'd1968;
    localparam logic [YEAR_W-1:0]  YEAR_BASE_JF  = 12'd1969;
    localparam logic [SUM_W-1:0]   DAYS_PER_YEAR = 17'd365;
    localparam logic [SUM_W-1:0]   DAYS_BIAS     = 17'd702;
    localparam logic [DAYS_W:0]    EPOCH_WDAY    = 17'd3;
    localparam logic [SUM_W-1:0]   SECS_PER_DAY  = 17'd86400;
    localparam logic [SUM_W-1:0]   MOD7_RECIP    = 17'd74899;
    localparam logic [WDAY_W:0]    DAYS_PER_WEEK = 4'd7;

    // Month length, February as non-leap; codes outside 1..12 give zero.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Day offset (367 * m) / 12 for the March-based month index 1..12.
    function automatic logic [8:0] month_ofs(input logic [MONTH_W-1:0] m);
        logic [8:0] ofs;
        case (m)
            4'd1:    ofs = 9'd30;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd91;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd152;
            4'd6:    ofs = 9'd183;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd244;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd305;
            4'd11:   ofs = 9'd336;
            4'd12:   ofs = 9'd367;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

// File: hdl/date_validate_epoch_weekday.sv
// ----------------------------------------------------------------------------
// date_validate_epoch_weekday
// Calendar date check with day count and seconds since 1970-01-01 and weekday.
// ----------------------------------------------------------------------------
// Pipeline: four registered stages (check, day count, products, output)
//   lie between the input transaction and the result transaction.
// Throughput: one transaction per cycle unless m_ready stalls; each of the
//   four stages holds and fills independently; a stall loses and repeats nothing.
// Reset: aresetn (synchronous, active low) clears all stage valid bits.
// ----------------------------------------------------------------------------
module date_validate_epoch_weekday (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dvew_pkg::DAY_W-1:0]   s_day_of_month,
    input  logic [dvew_pkg::MONTH_W-1:0] s_month_number,
    input  logic [dvew_pkg::YEAR_W-1:0]  s_year_number,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_date_valid,
    output logic [dvew_pkg::DAYS_W-1:0]  m_epoch_days,
    output logic [dvew_pkg::SECS_W-1:0]  m_epoch_seconds,
    output logic [dvew_pkg::WDAY_W-1:0]  m_weekday
);
    import dvew_pkg::*;

    logic en1, en2, en3, en4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // stage 1: check and March-based year/month
    logic                 ok_next, ok1_reg;
    logic [DAY_W-1:0]     lim;
    logic [YOFS_W-1:0]    yofs_next, yofs1_reg;
    logic [MONTH_W-1:0]   mshift_next, mshift1_reg;
    logic [DAY_W-1:0]     day1_reg;
    logic [YEAR_W-1:0]    ydiff;

    // stage 2: day count
    logic [SUM_W-1:0]     sum_next;
    logic [DAYS_W-1:0]    days2_reg;
    logic                 ok2_reg;

    // stage 3: products
    logic [DAYS_W:0]      wsum;
    logic [DAYS_W+SUM_W-1:0] secs_prod_next, secs3_reg;
    logic [DAYS_W+SUM_W:0]   q_prod_next, q3_reg;
    logic [DAYS_W:0]      wsum3_reg;
    logic [DAYS_W-1:0]    days3_reg;
    logic                 ok3_reg;

    // stage 4: output
    logic [DAYS_W:0]      quot;
    logic [DAYS_W+WDAY_W+1:0] qx7;
    logic [DAYS_W:0]      rem;
    logic                 ok4_reg;
    logic [DAYS_W-1:0]    days4_reg;
    logic [SECS_W-1:0]    secs4_reg;
    logic [WDAY_W-1:0]    wday4_reg;

    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;

    always_comb begin
        lim = month_len(s_month_number);
        if (s_month_number == 4'd2 && s_year_number[1:0] == 2'b00) begin
            lim = 5'd29;
        end
        ok_next = (s_year_number >= YEAR_MIN) && (s_year_number <= YEAR_MAX) &&
                  (s_day_of_month != '0) && (s_day_of_month <= lim);
        if (s_month_number <= 4'd2) begin
            ydiff       = s_year_number - YEAR_BASE_JF;
            mshift_next = s_month_number + 4'd10;
        end else begin
            ydiff       = s_year_number - YEAR_BASE;
            mshift_next = s_month_number - 4'd2;
        end
        yofs_next = ydiff[YOFS_W-1:0];
    end

    always_comb begin
        sum_next = yofs1_reg * DAYS_PER_YEAR
                 + SUM_W'(yofs1_reg[YOFS_W-1:2])
                 + SUM_W'(month_ofs(mshift1_reg))
                 + SUM_W'(day1_reg)
                 - DAYS_BIAS;
    end

    always_comb begin
        wsum           = {1'b0, days2_reg} + EPOCH_WDAY;
        secs_prod_next = days2_reg * SECS_PER_DAY;
        q_prod_next    = wsum * MOD7_RECIP;
    end

    always_comb begin
        quot = (DAYS_W+1)'(q3_reg[DAYS_W+SUM_W:MOD_SHIFT]);
        qx7  = quot * DAYS_PER_WEEK;
        rem  = wsum3_reg - qx7[DAYS_W:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            ok1_reg     <= ok_next;
            yofs1_reg   <= yofs_next;
            mshift1_reg <= mshift_next;
            day1_reg    <= s_day_of_month;
        end
        if (en2) begin
            ok2_reg   <= ok1_reg;
            days2_reg <= ok1_reg ? sum_next[DAYS_W-1:0] : '0;
        end
        if (en3) begin
            ok3_reg   <= ok2_reg;
            days3_reg <= days2_reg;
            secs3_reg <= secs_prod_next;
            q3_reg    <= q_prod_next;
            wsum3_reg <= wsum;
        end
        if (en4) begin
            ok4_reg   <= ok3_reg;
            days4_reg <= days3_reg;
            secs4_reg <= secs3_reg[SECS_W-1:0];
            wday4_reg <= ok3_reg ? rem[WDAY_W-1:0] : '0;
        end
    end

    assign m_valid         = v4_reg;
    assign m_date_valid    = ok4_reg;
    assign m_epoch_days    = days4_reg;
    assign m_epoch_seconds = secs4_reg;
    assign m_weekday       = wday4_reg;

endmodule
